[design/idle_timeout_power_policy_assert.svh]
// Assertion macros for the inactivity power policy RTL.
`ifndef IDLE_TIMEOUT_POWER_POLICY_ASSERT_SVH
`define IDLE_TIMEOUT_POWER_POLICY_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define ITPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define ITPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/itpp_pkg.sv]
// Types, constants and register codes of the inactivity power policy.
package itpp_pkg;

  localparam int RATE_W         = 20;        // holds tick rates up to 1 MHz
  localparam int TICK_RATE_HZ_DEF = 1000;
  localparam int TS_W           = 32;
  localparam int LED_MS_W       = 32;
  localparam int OFF_S_W        = 16;
  localparam int VOTE_W         = 4;
  localparam int MS_PER_S       = 1000;
  localparam int SCALED_W       = TS_W + 10;  // ticks * 1000
  localparam int LED_THR_W      = LED_MS_W + RATE_W;
  localparam int OFF_THR_W      = OFF_S_W + RATE_W;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [LED_MS_W-1:0] LED_IDLE_MS_RST   = LED_MS_W'(30000);
  localparam logic [OFF_S_W-1:0]  OFF_TIMEOUT_S_RST = OFF_S_W'(300);

  // register select, taken from paddr[2]
  localparam logic REG_LED_IDLE    = 1'b0;
  localparam logic REG_OFF_TIMEOUT = 1'b1;

  typedef enum logic {
    CMD_ACTIVITY = 1'b0,
    CMD_TICK     = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [TS_W-1:0]   now_ticks;
    logic [VOTE_W-1:0] usb_votes;
    logic [VOTE_W-1:0] ble_votes;
    logic [VOTE_W-1:0] flash_votes;
    logic              vbus_present;
    logic              app_running;
  } item_t;

  typedef struct packed {
    logic led_idle;
    logic led_changed;
    logic adv_slow;
    logic shutdown_req;
  } result_t;

  // thresholds in units of ticks*1000 (LED) and ticks (power off)
  typedef struct packed {
    logic [LED_THR_W-1:0] led_thr;
    logic [OFF_THR_W-1:0] off_thr;
    logic                 off_en;
  } thr_t;

  function automatic logic [SCALED_W-1:0] scale_ms(input logic [TS_W-1:0] ticks);
    scale_ms = SCALED_W'(ticks) * SCALED_W'(MS_PER_S);
  endfunction

endpackage

[design/idle_timeout_power_policy.sv]
// Inactivity power policy: activity events and policy ticks go in, and one
// result (LED idle, LED idle change, slow advertising, shutdown request) comes
// out per item. One item is accepted every clock cycle while in_stall is low;
// an item passes an input register and then a result register before its
// result is offered. The idle decision is a single subtract, a multiply by
// 1000 and a compare against thresholds that are scaled by TICK_RATE_HZ when
// a configuration register is written.
module idle_timeout_power_policy
  import itpp_pkg::*;
#(
  parameter int TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [TS_W-1:0]   in_now_ticks,
  input  logic [VOTE_W-1:0] in_usb_votes,
  input  logic [VOTE_W-1:0] in_ble_votes,
  input  logic [VOTE_W-1:0] in_flash_votes,
  input  logic              in_vbus_present,
  input  logic              in_app_running,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_led_idle,
  output logic              out_led_changed,
  output logic              out_adv_slow,
  output logic              out_shutdown_req,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  item_t   s1_item_r;
  logic    s1_valid_r;
  result_t out_res_r;
  logic    out_valid_r;
  item_t   in_item;
  result_t res;
  thr_t    thr;
  logic    advance;
  logic    s1_load;
  logic    fire;

  assign in_item.cmd          = cmd_t'(in_cmd);
  assign in_item.now_ticks    = in_now_ticks;
  assign in_item.usb_votes    = in_usb_votes;
  assign in_item.ble_votes    = in_ble_votes;
  assign in_item.flash_votes  = in_flash_votes;
  assign in_item.vbus_present = in_vbus_present;
  assign in_item.app_running  = in_app_running;

  // result register frees up when empty or taken this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || advance;
  assign fire     = s1_valid_r && advance;
  assign in_stall = !s1_load;
  assign pready   = 1'b1;

  itpp_cfg #(
    .TICK_RATE_HZ(TICK_RATE_HZ)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .thr    (thr)
  );

  itpp_policy u_policy (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (s1_item_r),
    .thr  (thr),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_idle     = out_res_r.led_idle;
  assign out_led_changed  = out_res_r.led_changed;
  assign out_adv_slow     = out_res_r.adv_slow;
  assign out_shutdown_req = out_res_r.shutdown_req;

`include "idle_timeout_power_policy_assert.svh"

  `ITPP_ASSERT_NEXT(a_activity_clears, fire && s1_item_r.cmd == CMD_ACTIVITY,
    !out_led_idle && !out_led_changed && !out_shutdown_req,
    "activity transfer produced idle, change or shutdown")
  `ITPP_ASSERT_NEXT(a_vbus_blocks_off, fire && s1_item_r.vbus_present,
    !out_shutdown_req, "shutdown requested with external supply present")
  `ITPP_ASSERT_NEXT(a_slow_adv_idle, fire && s1_item_r.cmd == CMD_TICK,
    !out_adv_slow || out_led_idle, "slow advertising selected while not idle")

endmodule

[design/itpp_cfg.sv]
// Configuration registers and precomputed idle thresholds.
module itpp_cfg
  import itpp_pkg::*;
#(
  parameter int TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output thr_t              thr
);

  localparam logic [RATE_W-1:0] RATE = RATE_W'(TICK_RATE_HZ);
  localparam logic [LED_THR_W-1:0] LED_THR_RST =
    LED_THR_W'(LED_THR_W'(LED_IDLE_MS_RST) * LED_THR_W'(RATE));
  localparam logic [OFF_THR_W-1:0] OFF_THR_RST =
    OFF_THR_W'(OFF_THR_W'(OFF_TIMEOUT_S_RST) * OFF_THR_W'(RATE));

  logic [LED_MS_W-1:0]  led_idle_ms_r;
  logic [OFF_S_W-1:0]   off_timeout_s_r;
  logic [LED_THR_W-1:0] led_thr_r;
  logic [OFF_THR_W-1:0] off_thr_r;
  logic                 wr;
  logic                 sel;

  assign wr  = psel && penable && pwrite;
  assign sel = paddr[2];

  // threshold products are formed at write time, off the item path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_idle_ms_r   <= LED_IDLE_MS_RST;
      off_timeout_s_r <= OFF_TIMEOUT_S_RST;
      led_thr_r       <= LED_THR_RST;
      off_thr_r       <= OFF_THR_RST;
    end else if (wr) begin
      unique case (sel)
        REG_LED_IDLE: begin
          led_idle_ms_r <= pwdata[LED_MS_W-1:0];
          led_thr_r     <= LED_THR_W'(pwdata[LED_MS_W-1:0]) * LED_THR_W'(RATE);
        end
        REG_OFF_TIMEOUT: begin
          off_timeout_s_r <= pwdata[OFF_S_W-1:0];
          off_thr_r       <= OFF_THR_W'(pwdata[OFF_S_W-1:0]) * OFF_THR_W'(RATE);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_LED_IDLE:    prdata = DATA_W'(led_idle_ms_r);
      REG_OFF_TIMEOUT: prdata = DATA_W'(off_timeout_s_r);
      default:         prdata = '0;
    endcase
  end

  assign thr.led_thr = led_thr_r;
  assign thr.off_thr = off_thr_r;
  assign thr.off_en  = (off_timeout_s_r != '0);

endmodule

[design/itpp_policy.sv]
// Policy state and per-item decision logic.
module itpp_policy
  import itpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  thr_t    thr,
  output result_t res
);

  logic [TS_W-1:0]   last_activity_r;
  logic              idle_flag_r;
  logic [VOTE_W-1:0] prev_usb_r;
  logic [VOTE_W-1:0] prev_ble_r;
  logic              prev_seen_r;
  logic              adv_slow_r;

  logic [TS_W-1:0]     last_activity_nxt;
  logic                idle_flag_nxt;
  logic                adv_slow_nxt;
  logic                is_tick;
  logic                vote_rise;
  logic [TS_W-1:0]     elapsed;
  logic [SCALED_W-1:0] elapsed_ms_x;
  logic                idle;
  logic                quiet;
  logic                off_due;

  assign is_tick   = (item.cmd == CMD_TICK);
  assign vote_rise = prev_seen_r &&
                     (item.usb_votes > prev_usb_r || item.ble_votes > prev_ble_r);

  // a vote rise restarts the idle time at this very tick
  assign elapsed      = vote_rise ? '0 : item.now_ticks - last_activity_r;
  assign elapsed_ms_x = scale_ms(elapsed);

  // floor(elapsed*1000/rate) >= ms  <=>  elapsed*1000 >= ms*rate
  assign idle    = LED_THR_W'(elapsed_ms_x) >= thr.led_thr;
  assign off_due = OFF_THR_W'(elapsed) >= thr.off_thr;
  assign quiet   = !item.vbus_present && !item.app_running &&
                   item.usb_votes == '0 && item.ble_votes == '0 &&
                   item.flash_votes == '0;

  always_comb begin
    last_activity_nxt = last_activity_r;
    idle_flag_nxt     = idle_flag_r;
    adv_slow_nxt      = adv_slow_r;
    res               = '0;
    unique case (item.cmd)
      CMD_ACTIVITY: begin
        last_activity_nxt = item.now_ticks;
        idle_flag_nxt     = 1'b0;
        res.adv_slow      = adv_slow_r;
      end
      CMD_TICK: begin
        if (vote_rise) begin
          last_activity_nxt = item.now_ticks;
        end
        idle_flag_nxt    = idle;
        adv_slow_nxt     = idle && item.ble_votes == '0;
        res.led_idle     = idle;
        res.led_changed  = idle != (idle_flag_r && !vote_rise);
        res.adv_slow     = adv_slow_nxt;
        res.shutdown_req = thr.off_en && quiet && off_due;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_activity_r <= '0;
      idle_flag_r     <= 1'b0;
      prev_usb_r      <= '0;
      prev_ble_r      <= '0;
      prev_seen_r     <= 1'b0;
      adv_slow_r      <= 1'b0;
    end else if (fire) begin
      last_activity_r <= last_activity_nxt;
      idle_flag_r     <= idle_flag_nxt;
      adv_slow_r      <= adv_slow_nxt;
      if (is_tick) begin
        prev_usb_r  <= item.usb_votes;
        prev_ble_r  <= item.ble_votes;
        prev_seen_r <= 1'b1;
      end
    end
  end

endmodule
